// ----- design/bds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bds_pkg;

    localparam int unsigned REF_W  = 32;
    localparam int unsigned BAUD_W = 24;
    localparam int unsigned CD_W   = 16;
    localparam int unsigned BDIV_W = 8;

    localparam logic [BDIV_W-1:0] BDIV_FIRST = 8'd4;
    localparam logic [BDIV_W-1:0] BDIV_LAST  = 8'd255;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [REF_W-1:0] dividend;
        logic [REF_W-1:0] divisor;
    } div_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic             done;
        logic [REF_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- design/bds_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bds_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bds_pkg::div_req_t req,
    output bds_pkg::div_rsp_t      rsp
);

    localparam int unsigned W  = bds_pkg::REF_W;
    localparam int unsigned CW = $clog2(W);

    logic [W:0]    rem_reg,  rem_next;
    logic [W-1:0]  quo_reg,  quo_next;
    logic [W-1:0]  den_reg,  den_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [W:0]    rem_shift;
    logic [W:0]    rem_diff;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg[W-1:0], quo_reg[W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!rem_diff[W]) begin
                rem_next = rem_diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- design/bds_search.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bds_search (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bds_pkg::REF_W-1:0]     ref_clock_hz,
    input  wire logic [bds_pkg::BAUD_W-1:0]    target_baud,
    input  wire logic                          slot_free,
    output logic                               idle,
    output logic                               res_valid,
    output logic [bds_pkg::CD_W-1:0]           res_cd,
    output logic [bds_pkg::BDIV_W-1:0]         res_bdiv,
    output logic                               res_found
);

    localparam int unsigned RW = bds_pkg::REF_W;
    localparam int unsigned BW = bds_pkg::BAUD_W;
    localparam int unsigned CW = bds_pkg::CD_W;
    localparam int unsigned DW = bds_pkg::BDIV_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_MUL    = 6'b000010,
        S_DGO    = 6'b000100,
        S_DWAIT  = 6'b001000,
        S_EVAL   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [RW-1:0] ref_reg,   ref_next;
    logic [BW-1:0] baud_reg,  baud_next;
    logic [DW-1:0] b_reg,     b_next;
    logic          phase_reg, phase_next;   // 0: clock divisor, 1: achieved rate
    logic [CW-1:0] cd_reg,    cd_next;
    logic [RW-1:0] prod_reg,  prod_next;
    logic [RW-1:0] err_reg,   err_next;     // best error so far
    logic [CW-1:0] bcd_reg,   bcd_next;
    logic [DW-1:0] bb_reg,    bb_next;
    logic          hit_reg,   hit_next;

    bds_pkg::div_req_t div_req;
    bds_pkg::div_rsp_t div_rsp;

    logic [BW-1:0] mul_a;
    logic [DW:0]   mul_b;
    logic [RW:0]   prod_full;
    logic [RW-1:0] q;
    logic [RW-1:0] baud_ext;
    logic [RW-1:0] err;
    logic          cd_ok;

    bds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // shared multiplier: baud*(b+1) first, then cd*(b+1)
    assign mul_a     = phase_reg ? {{(BW-CW){1'b0}}, cd_reg} : baud_reg;
    assign mul_b     = {1'b0, b_reg} + (DW+1)'(1);
    assign prod_full = {{(RW+1-BW){1'b0}}, mul_a} * {{(RW-DW){1'b0}}, mul_b};

    assign div_req.start    = (state_reg == S_DGO);
    assign div_req.dividend = ref_reg;
    assign div_req.divisor  = prod_reg;

    assign q        = div_rsp.quotient;
    assign baud_ext = {{(RW-BW){1'b0}}, baud_reg};
    assign err      = (q > baud_ext) ? (q - baud_ext) : (baud_ext - q);
    assign cd_ok    = (q != '0) && (q[RW-1:CW] == '0);

    always_comb begin
        state_next = state_reg;
        ref_next   = ref_reg;
        baud_next  = baud_reg;
        b_next     = b_reg;
        phase_next = phase_reg;
        cd_next    = cd_reg;
        prod_next  = prod_reg;
        err_next   = err_reg;
        bcd_next   = bcd_reg;
        bb_next    = bb_reg;
        hit_next   = hit_reg;
        res_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    ref_next   = ref_clock_hz;
                    baud_next  = target_baud;
                    b_next     = bds_pkg::BDIV_FIRST;
                    phase_next = 1'b0;
                    hit_next   = 1'b0;
                    err_next   = '1;
                    bcd_next   = '0;
                    bb_next    = '0;
                    if (ref_clock_hz == '0 || target_baud == '0) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                prod_next  = prod_full[RW-1:0];
                state_next = S_DGO;
            end
            S_DGO: begin
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!phase_reg && cd_ok) begin
                    cd_next    = q[CW-1:0];
                    phase_next = 1'b1;
                    state_next = S_MUL;
                end else begin
                    if (phase_reg && (!hit_reg || err < err_reg)) begin
                        err_next = err;
                        bcd_next = cd_reg;
                        bb_next  = b_reg;
                        hit_next = 1'b1;
                    end
                    phase_next = 1'b0;
                    if (b_reg == bds_pkg::BDIV_LAST) begin
                        state_next = S_FINISH;
                    end else begin
                        b_next     = b_reg + DW'(1);
                        state_next = S_MUL;
                    end
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            hit_reg   <= 1'b0;
            b_reg     <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            hit_reg   <= hit_next;
            b_reg     <= b_next;
        end
        ref_reg  <= ref_next;
        baud_reg <= baud_next;
        cd_reg   <= cd_next;
        prod_reg <= prod_next;
        err_reg  <= err_next;
        bcd_reg  <= bcd_next;
        bb_reg   <= bb_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_found = hit_reg;
    assign res_cd    = hit_reg ? bcd_reg : '0;
    assign res_bdiv  = hit_reg ? bb_reg : '0;

endmodule

`default_nettype wire

// ----- design/baud_divisor_search_top.sv -----
// baud divisor search: picks the clock divisor and bit divisor pair whose
// achieved rate ref/(cd*(bdiv+1)) lies closest to the requested baud rate.
// input beat: s_ref_clock_hz and s_target_baud on an s_valid/s_ready pair.
// result beat: m_clock_divisor, m_bit_divisor, m_found on m_valid/m_ready,
// one result beat per input beat. no usable pair, a zero clock or a zero baud
// gives m_found low and both divisors zero.
// search steps: each bit divisor from 4 to 255 takes one multiply, a divider
// launch, a restoring divide and an evaluate, and a second multiply and divide
// when its clock divisor is in range; the search time is set by the single
// shared 32-bit divider; zero inputs skip the search and go straight to the
// finish state.
// throughput: one search at a time; s_ready is high only while no search runs.
// the finished result sits in an output register, so a new input beat can be
// taken while it waits; if that search ends before the receiver takes the
// old result, it holds until the output register frees.
// reset: synchronous active-low aresetn clears the sequencer and m_valid;
// the block comes out of reset ready.
`timescale 1ns / 1ps
`default_nettype none

module baud_divisor_search_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bds_pkg::REF_W-1:0]     s_ref_clock_hz,
    input  wire logic [bds_pkg::BAUD_W-1:0]    s_target_baud,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bds_pkg::CD_W-1:0]           m_clock_divisor,
    output logic [bds_pkg::BDIV_W-1:0]         m_bit_divisor,
    output logic                               m_found
);

    logic                          idle;
    logic                          slot_free;
    logic                          res_valid;
    logic [bds_pkg::CD_W-1:0]      res_cd;
    logic [bds_pkg::BDIV_W-1:0]    res_bdiv;
    logic                          res_found;

    logic                          valid_reg, valid_next;
    logic [bds_pkg::CD_W-1:0]      cd_reg,    cd_next;
    logic [bds_pkg::BDIV_W-1:0]    bdiv_reg,  bdiv_next;
    logic                          found_reg, found_next;

    assign s_ready   = idle;
    assign slot_free = !valid_reg || m_ready;

    bds_search u_search (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_valid && idle),
        .ref_clock_hz (s_ref_clock_hz),
        .target_baud  (s_target_baud),
        .slot_free    (slot_free),
        .idle         (idle),
        .res_valid    (res_valid),
        .res_cd       (res_cd),
        .res_bdiv     (res_bdiv),
        .res_found    (res_found)
    );

    always_comb begin
        valid_next = valid_reg;
        cd_next    = cd_reg;
        bdiv_next  = bdiv_reg;
        found_next = found_reg;
        if (res_valid) begin
            valid_next = 1'b1;
            cd_next    = res_cd;
            bdiv_next  = res_bdiv;
            found_next = res_found;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cd_reg    <= cd_next;
        bdiv_reg  <= bdiv_next;
        found_reg <= found_next;
    end

    assign m_valid         = valid_reg;
    assign m_clock_divisor = cd_reg;
    assign m_bit_divisor   = bdiv_reg;
    assign m_found         = found_reg;

endmodule

`default_nettype wire
